// File: rtl/bspq_pkg.sv
// ============================================================================
// bspq_pkg: shared types and constants of the sorted priority queue
// Beat formats of the command and result channels, the per-cell command
// broadcast, and the status codes.
// ============================================================================
package bspq_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 64;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Bit pattern of a negative infinity double.
    localparam logic [VAL_W-1:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

    typedef struct packed {
        logic                     op;
        logic signed [KEY_W-1:0]  prio_key;
        logic [VAL_W-1:0]         payload;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] out_value;
    } t_out_beat;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                     insert;
        logic                     extract;
        logic signed [KEY_W-1:0]  key;
        logic [VAL_W-1:0]         value;
    } t_cell_cmd;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic [VAL_W-1:0]         value;
    } t_entry;

endpackage

// File: rtl/bounded_sorted_priority_queue.sv
// ============================================================================
// bounded_sorted_priority_queue: minimum priority queue in a sorted chain
// A row of CAPACITY cells kept in ascending key order, head at cell 0.
// ============================================================================
// Usage:
//   Command channel: drive i_in with start high. The beat is taken at any
//   edge where start is high and busy is low; busy stays low, so one command
//   is taken every cycle. op selects insert (key and payload are stored) or
//   extract (the head entry leaves and its payload is returned).
//   Result channel: exactly one result beat per command, on o_out with o_done
//   high for one cycle, the cycle after the command was taken.
//   Throughput is one command per cycle: every cell compares the broadcast
//   key against its own in the same cycle and then keeps, loads or shifts,
//   so the whole chain updates together on an insert or extract.
//   Equal keys leave in arrival order. An insert into a full queue returns
//   status full, an extract from an empty one returns status empty and the
//   negative infinity bit pattern; the queue is left unchanged in both cases.
//   Reset empties the queue at once by clearing the cell valid bits.
//   The receiver cannot stall; results must be taken when o_done is high.
// ============================================================================
module bounded_sorted_priority_queue
    import bspq_pkg::*;
#(
    parameter int CAPACITY = 128
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_in,
    output logic      o_done,
    output t_out_beat o_out
);

    t_entry    w_entry [CAPACITY];
    logic      w_le    [CAPACITY];
    t_cell_cmd w_cmd;
    logic      w_accept;
    logic      w_full;
    logic      w_empty;

    logic      r_done;
    t_out_beat r_out;
    t_out_beat n_out;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = w_entry[CAPACITY-1].valid;
    assign w_empty  = !w_entry[0].valid;

    always_comb begin
        w_cmd.insert  = w_accept && (i_in.op == OP_INSERT) && !w_full;
        w_cmd.extract = w_accept && (i_in.op == OP_EXTRACT) && !w_empty;
        w_cmd.key     = i_in.prio_key;
        w_cmd.value   = i_in.payload;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_le;
        t_entry w_right;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_le = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_le = w_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        bspq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_left    (w_left),
            .i_left_le (w_left_le),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_le      (w_le[g])
        );
    end

    always_comb begin
        n_out.status    = ST_OK;
        n_out.out_value = '0;
        if (i_in.op == OP_INSERT) begin
            if (w_full) begin
                n_out.status = ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_out.status    = ST_EMPTY;
                n_out.out_value = NEG_INF_BITS;
            end else begin
                n_out.out_value = w_entry[0].value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
        end
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

// File: rtl/bspq_cell.sv
// ============================================================================
// bspq_cell: one slot of the sorted register chain
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// the entry of its left neighbor; on extract it takes its right neighbor's.
// ============================================================================
module bspq_cell
    import bspq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_left,
    input  logic      i_left_le,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_le
);

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic [VAL_W-1:0]        r_value;
    logic                    n_valid;
    logic signed [KEY_W-1:0] n_key;
    logic [VAL_W-1:0]        n_value;

    // An empty cell acts as a key above every real key.
    assign o_le    = r_valid && (r_key <= i_cmd.key);
    assign o_entry = '{valid: r_valid, key: r_key, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        if (i_cmd.insert && !o_le) begin
            if (i_left_le) begin
                n_valid = 1'b1;
                n_key   = i_cmd.key;
                n_value = i_cmd.value;
            end else begin
                n_valid = i_left.valid;
                n_key   = i_left.key;
                n_value = i_left.value;
            end
        end else if (i_cmd.extract) begin
            n_valid = i_right.valid;
            n_key   = i_right.key;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key   <= n_key;
        r_value <= n_value;
    end

endmodule

// File: rtl/bspq_chk.sv
// ============================================================================
// bspq_chk: port-level checks of the sorted priority queue
// Watches the command and result channels and is bound to the top level.
// ============================================================================
module bspq_chk
    import bspq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_beat  i_in,
    input logic      o_done,
    input t_out_beat o_out
);

    // Every accepted command yields exactly one result beat in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted command gave no result beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result beat without a command");

    // An insert never returns a value.
    a_insert_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_in.op == OP_INSERT)) |=> (o_out.out_value == '0))
        else $error("insert returned a nonzero value");

    // The queue is empty right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        (!i_rst_n ##1 (i_rst_n && start && !busy && (i_in.op == OP_EXTRACT)))
        |=> (o_out.status == ST_EMPTY))
        else $error("extract after reset did not report empty");

endmodule

bind bounded_sorted_priority_queue bspq_chk u_bspq_chk (.*);
